// ----- sv/assert_macros.svh -----
// Assertion macros used by the cipher top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an implication holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/xcc_pkg.sv -----
// Types and constants for the XChaCha20 stream cipher.
// No dependencies.
package xcc_pkg;
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_CRYPT   = 2'd1;
    localparam logic [1:0] CMD_DISCARD = 2'd2;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;
    localparam logic [2:0] REG_NONCE2 = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [31:0] skip_length;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } cfg_word_t;

    // Word indexes a,b,c,d of quarter-round n (0..7) of a double round.
    function automatic logic [15:0] qr_idx(input logic [2:0] n);
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
        a = {2'b00, n[1:0]};
        if (!n[2])
        begin
            b = a + 4'd4;
            c = a + 4'd8;
            d = a + 4'd12;
        end
        else
        begin
            b = {2'b01, n[1:0] + 2'd1};
            c = {2'b10, n[1:0] + 2'd2};
            d = {2'b11, n[1:0] + 2'd3};
        end
        return {a, b, c, d};
    endfunction
endpackage

// ----- sv/xcc_stream_if.sv -----
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
interface xcc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/xchacha20_stream_cipher_top.sv -----
// XChaCha20 stream cipher top level with a shared quarter-round unit.
// Depends on xcc_pkg, xcc_stream_if and assert_macros.svh.
//
// One command word per accepted input. A crypt word that finds the block
// used up first runs DOUBLE_ROUNDS*8 quarter-round steps on the one
// quarter-round unit plus 16 add-back steps, and its byte shows after them.
// Otherwise a crypt byte passes the decode and output states into the
// output register, and the next word is taken the cycle after the byte is
// delivered. A restart runs the rounds once.
// A discard that ends partway into a new block runs the rounds and add-back
// steps to build that block.
// The output byte waits in an output register; the next word is taken
// once it is delivered. No memory clearing pass is needed after reset.
`include "assert_macros.svh"
module xchacha20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input logic   clk,
    input logic   rst_n,
    xcc_stream_if.sink   in_ch,
    xcc_stream_if.source out_ch,
    xcc_stream_if.sink   cfg_ch
);
    import xcc_pkg::*;

    localparam int QRW = $clog2(DOUBLE_ROUNDS * 8 + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg [3];
    word_t       subkey_reg [8];
    word_t       tail_reg [2];
    logic [63:0] ctr_reg, ctr_next;
    state_t      w_reg, w_next;
    logic [6:0]  pos_reg, pos_next;
    logic [2:0]  st_reg, st_next;
    logic [QRW-1:0] qr_reg, qr_next;
    logic [3:0]  add_reg, add_next;
    logic        hmode_reg, hmode_next;
    in_word_t    cur_reg;
    logic [7:0]  obyte_reg, obyte_next;
    logic        ovalid_reg, ovalid_next;

    in_word_t  in_w;
    cfg_word_t cfg_w;
    assign in_w  = in_ch.payload;
    assign cfg_w = cfg_ch.payload;

    assign cfg_ch.ready   = 1'b1;
    assign in_ch.ready    = (st_reg == ST_IDLE) && !ovalid_reg;
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = obyte_reg;

    // Initial block state from subkey, counter and nonce tail.
    function automatic state_t block_in(input word_t sk [8], input logic [63:0] c,
                                        input word_t t [2]);
        state_t s;
        s[0] = SIGMA0; s[1] = SIGMA1; s[2] = SIGMA2; s[3] = SIGMA3;
        for (int i = 0; i < 8; i++)
            s[4+i] = sk[i];
        s[12] = c[31:0]; s[13] = c[63:32];
        s[14] = t[0]; s[15] = t[1];
        return s;
    endfunction

    state_t bin;
    assign bin = block_in(subkey_reg, ctr_reg - 64'd1, tail_reg);

    // Shared quarter-round unit.
    logic [15:0] qi;
    logic [3:0]  ia, ib, ic, id;
    word_t a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
    assign qi = qr_idx(qr_reg[2:0]);
    assign {ia, ib, ic, id} = qi;
    always_comb
    begin
        a0 = w_reg[ia] + w_reg[ib];
        d0 = w_reg[id] ^ a0; d0 = {d0[15:0], d0[31:16]};
        c0 = w_reg[ic] + d0;
        b0 = w_reg[ib] ^ c0; b0 = {b0[19:0], b0[31:20]};
        a1 = a0 + b0;
        d1 = d0 ^ a1; d1 = {d1[23:0], d1[31:24]};
        c1 = c0 + d1;
        b1 = b0 ^ c1; b1 = {b1[24:0], b1[31:25]};
        a2 = a1; b2 = b1; c2 = c1; d2 = d1;
    end

    logic [5:0]  bsel;
    logic [31:0] room, rest;
    word_t       kw;
    always_comb
    begin
        st_next     = st_reg;
        w_next      = w_reg;
        ctr_next    = ctr_reg;
        pos_next    = pos_reg;
        qr_next     = qr_reg;
        add_next    = add_reg;
        hmode_next  = hmode_reg;
        obyte_next  = obyte_reg;
        ovalid_next = ovalid_reg;
        room = 32'd0;
        rest = 32'd0;
        bsel = pos_reg[5:0];
        kw   = w_reg[bsel[5:2]];
        if (out_ch.ready)
            ovalid_next = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                    st_next = ST_DEC;
            end
            ST_DEC:
            begin
                st_next = ST_IDLE;
                case (cur_reg.cmd)
                    CMD_RESTART:
                    begin
                        w_next[0] = SIGMA0; w_next[1] = SIGMA1;
                        w_next[2] = SIGMA2; w_next[3] = SIGMA3;
                        for (int i = 0; i < 4; i++)
                        begin
                            w_next[4+2*i] = key_reg[i][31:0];
                            w_next[5+2*i] = key_reg[i][63:32];
                        end
                        w_next[12] = nonce_reg[0][31:0];
                        w_next[13] = nonce_reg[0][63:32];
                        w_next[14] = nonce_reg[1][31:0];
                        w_next[15] = nonce_reg[1][63:32];
                        // Clear the counter and mark the keystream used up.
                        ctr_next   = '0;
                        pos_next   = 7'd64;
                        hmode_next = 1'b1;
                        qr_next    = '0;
                        st_next    = ST_ROUND;
                    end
                    CMD_CRYPT:
                    begin
                        if (pos_reg[6])
                        begin
                            w_next     = block_in(subkey_reg, ctr_reg, tail_reg);
                            ctr_next   = ctr_reg + 64'd1;
                            pos_next   = 7'd0;
                            hmode_next = 1'b0;
                            qr_next    = '0;
                            st_next    = ST_ROUND;
                        end
                        else
                            st_next = ST_OUT;
                    end
                    CMD_DISCARD:
                    begin
                        rest = cur_reg.skip_length;
                        if (!pos_reg[6])
                        begin
                            room = 32'd64 - {25'd0, pos_reg};
                            if (rest < room)
                            begin
                                pos_next = pos_reg + rest[6:0];
                                rest = 32'd0;
                            end
                            else
                            begin
                                pos_next = 7'd64;
                                rest = rest - room;
                            end
                        end
                        if (rest[5:0] != 6'd0)
                        begin
                            w_next = block_in(subkey_reg, ctr_reg + {38'd0, rest[31:6]},
                                              tail_reg);
                            ctr_next   = ctr_reg + {38'd0, rest[31:6]} + 64'd1;
                            pos_next   = {1'b0, rest[5:0]};
                            hmode_next = 1'b0;
                            qr_next    = '0;
                            // The crypt case reuses ST_OUT; discard skips it.
                            st_next    = ST_ROUND;
                        end
                        else
                            ctr_next = ctr_reg + {38'd0, rest[31:6]};
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ROUND:
            begin
                w_next[ia] = a2; w_next[ib] = b2;
                w_next[ic] = c2; w_next[id] = d2;
                qr_next = qr_reg + 1'b1;
                if (qr_reg == QRW'(DOUBLE_ROUNDS * 8 - 1))
                begin
                    if (hmode_reg)
                        st_next = ST_IDLE;
                    else
                    begin
                        add_next = 4'd0;
                        st_next  = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                w_next[add_reg] = w_reg[add_reg] + bin[add_reg];
                add_next = add_reg + 4'd1;
                if (add_reg == 4'd15)
                    st_next = (cur_reg.cmd == CMD_CRYPT) ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                obyte_next  = cur_reg.data_byte ^ kw[{bsel[1:0], 3'b000} +: 8];
                ovalid_next = 1'b1;
                pos_next    = pos_reg + 7'd1;
                st_next     = ST_IDLE;
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            ctr_reg    <= '0;
            pos_reg    <= 7'd64;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                nonce_reg[i] <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            ctr_reg    <= ctr_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
            if (cfg_ch.valid)
            begin
                case (cfg_w.index)
                    REG_KEY0:   key_reg[0]   <= cfg_w.data;
                    REG_KEY1:   key_reg[1]   <= cfg_w.data;
                    REG_KEY2:   key_reg[2]   <= cfg_w.data;
                    REG_KEY3:   key_reg[3]   <= cfg_w.data;
                    REG_NONCE0: nonce_reg[0] <= cfg_w.data;
                    REG_NONCE1: nonce_reg[1] <= cfg_w.data;
                    REG_NONCE2: nonce_reg[2] <= cfg_w.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        qr_reg    <= qr_next;
        add_reg   <= add_next;
        hmode_reg <= hmode_next;
        obyte_reg <= obyte_next;
        if (in_ch.valid && in_ch.ready)
            cur_reg <= in_w;
        // Latch the subkey when the HChaCha20 rounds finish.
        if (st_reg == ST_ROUND && hmode_reg && qr_reg == QRW'(DOUBLE_ROUNDS * 8 - 1))
        begin
            for (int i = 0; i < 4; i++)
            begin
                subkey_reg[i]   <= w_next[i];
                subkey_reg[4+i] <= w_next[12+i];
            end
        end
        if (st_reg == ST_DEC && cur_reg.cmd == CMD_RESTART)
        begin
            tail_reg[0] <= nonce_reg[2][31:0];
            tail_reg[1] <= nonce_reg[2][63:32];
        end
    end

    `ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, st_reg == ST_IDLE)
    `ASSERT_NEXT(a_out_pos, clk, rst_n, st_reg == ST_OUT, ovalid_reg)
    `ASSERT_IMP(a_pos_range, clk, rst_n, st_reg == ST_OUT, !pos_reg[6])
endmodule
